// ===== sv/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants for the unique value set with running sum.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int SUM_W          = 37;

  // opcode field codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // status field codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_DUP       = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    K_INSERT,
    K_REMOVE,
    K_LOOKUP
  } op_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] operand_value;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [3:0]         match_index;
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [35:0] total_sum;
  } result_t;

endpackage

// ===== sv/uvs_front.sv =====
// ----------------------------------------------------------------------------
// uvs_front
// Accepts items, classifies the opcode, sign-extends or narrows the value to
// VALUE_BITS and holds them in a two-entry queue for the set engine.
// ----------------------------------------------------------------------------
module uvs_front #(
  parameter int VALUE_BITS = uvs_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  uvs_pkg::item_t          item,
  output logic                    q_valid,
  input  logic                    q_ready,
  output uvs_pkg::op_kind_t       q_kind,
  output logic [VALUE_BITS-1:0]   q_value
);
  import uvs_pkg::*;

  op_kind_t              kind_q  [2];
  logic [VALUE_BITS-1:0] value_q [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            fill;

  op_kind_t              kind_in;
  logic [VALUE_BITS+31:0] value_wide;
  logic                  push;
  logic                  pop;

  always_comb begin
    unique case (item.opcode)
      OP_INSERT: kind_in = K_INSERT;
      OP_REMOVE: kind_in = K_REMOVE;
      default:   kind_in = K_LOOKUP;
    endcase
  end

  assign value_wide = {{VALUE_BITS{item.operand_value[31]}}, item.operand_value};

  assign item_ready = (fill != 2'd2);
  assign push       = item_valid && item_ready;
  assign q_valid    = (fill != 2'd0);
  assign pop        = q_valid && q_ready;
  assign q_kind     = kind_q[rd_ptr];
  assign q_value    = value_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr]  <= kind_in;
      value_q[wr_ptr] <= value_wide[VALUE_BITS-1:0];
    end
  end

endmodule

// ===== sv/uvs_back.sv =====
// ----------------------------------------------------------------------------
// uvs_back
// Set engine: parallel compare against the stored entries, then insert,
// remove with gap closing, or look up, and load the result register.
// ----------------------------------------------------------------------------
module uvs_back #(
  parameter int CAPACITY   = uvs_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = uvs_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  uvs_pkg::op_kind_t     q_kind,
  input  logic [VALUE_BITS-1:0] q_value,
  output logic                  result_valid,
  input  logic                  result_ready,
  output uvs_pkg::result_t      result
);
  import uvs_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t                state;
  state_t                state_next;
  op_kind_t              kind_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [CAPACITY-1:0]   match;
  logic [VALUE_BITS-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      sum_next;
  result_t               result_next;

  logic                  load;
  logic                  fire;
  logic                  found;
  logic [IDX_W-1:0]      pos;
  logic                  ins_we;
  logic                  rem_we;
  logic [1:0]            status;
  logic [VALUE_BITS+SUM_W-1:0] value_wide;
  logic [SUM_W-1:0]      value_sum;
  logic [IDX_W+3:0]      pos_ext;
  logic [CNT_W+4:0]      count_ext;

  assign value_wide = {{SUM_W{value_r[VALUE_BITS-1]}}, value_r};
  assign value_sum  = value_wide[SUM_W-1:0];

  // entries are distinct, so at most one match bit is set
  always_comb begin
    found = |match;
    pos   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next  = state;
    q_ready     = 1'b0;
    load        = 1'b0;
    fire        = 1'b0;
    ins_we      = 1'b0;
    rem_we      = 1'b0;
    count_next  = count;
    sum_next    = sum;
    status      = ST_DONE;
    unique case (state)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          load       = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!result_valid || result_ready) begin
          fire       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    unique case (kind_r)
      K_INSERT: begin
        if (found) begin
          status = ST_DUP;
        end else if (count == CNT_W'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          ins_we     = fire;
          count_next = count + CNT_W'(1);
          sum_next   = sum + value_sum;
        end
      end
      K_REMOVE: begin
        if (found) begin
          rem_we     = fire;
          count_next = count - CNT_W'(1);
          sum_next   = sum - value_sum;
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: begin
        status = found ? ST_DONE : ST_NOT_FOUND;
      end
    endcase

    pos_ext                 = {4'b0, pos};
    count_ext               = {5'b0, count_next};
    result_next.found       = found;
    result_next.match_index = pos_ext[3:0];
    result_next.status      = status;
    result_next.entry_count = count_ext[4:0];
    result_next.total_sum   = sum_next[35:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      sum          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        count        <= count_next;
        sum          <= sum_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= q_kind;
      value_r <= q_value;
    end
    if (fire) begin
      result <= result_next;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] <= (CNT_W'(i) < count) && (entries[i] == value_r);
    end
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_entry
    if (gi < CAPACITY - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (ins_we && (count == CNT_W'(gi))) begin
          entries[gi] <= value_r;
        end else if (rem_we && (IDX_W'(gi) >= pos)) begin
          entries[gi] <= entries[gi+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (ins_we && (count == CNT_W'(gi))) begin
          entries[gi] <= value_r;
        end
      end
    end
  end

endmodule

// ===== sv/unique_value_set_with_sum.sv =====
// ----------------------------------------------------------------------------
// unique_value_set_with_sum
// Ordered set of distinct signed values with count and running sum.
// ----------------------------------------------------------------------------
// an item passes the front queue, then the engine idle (load), compare and
//   execute states; execute stalls until any earlier result is taken, and the
//   engine takes no new item until done with the last; the queue holds two ahead
// reset: clears queue, count, sum and result valid; entries are not cleared
module unique_value_set_with_sum #(
  parameter int CAPACITY   = uvs_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = uvs_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  uvs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output uvs_pkg::result_t result
);
  import uvs_pkg::*;

  logic                  q_valid;
  logic                  q_ready;
  op_kind_t              q_kind;
  logic [VALUE_BITS-1:0] q_value;

  uvs_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_kind     (q_kind),
    .q_value    (q_value)
  );

  uvs_back #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_kind       (q_kind),
    .q_value      (q_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== sv/uvs_checker.sv =====
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks for the unique value set, bound to the top level.
// ----------------------------------------------------------------------------
module uvs_checker #(
  parameter int CAPACITY = uvs_pkg::CAPACITY_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input uvs_pkg::result_t result
);
  import uvs_pkg::*;

  // a pending result holds until transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed before transfer");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

  // miss statuses carry no match
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_NOT_FOUND || result.status == ST_FULL)
    |-> !result.found && result.match_index == 4'd0)
    else $error("miss status with match");

  // duplicate means the value was there
  a_dup_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_DUP |-> result.found)
    else $error("duplicate without match");

  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (CAPACITY >= 32) || (int'(result.entry_count) <= CAPACITY))
    else $error("count above capacity");

endmodule

bind unique_value_set_with_sum uvs_checker #(
  .CAPACITY(CAPACITY)
) u_uvs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
